[design/srfo_pkg.sv]
package srfo_pkg;

    localparam int MAX_SECTIONS = 16;
    localparam int IDX_W        = (MAX_SECTIONS > 1) ? $clog2(MAX_SECTIONS) : 1;
    localparam int CMP_W        = 8;
    localparam int SLOT_W       = 4;
    localparam int COUNT_W      = 5;
    localparam int ADDR_W       = 32;
    localparam int CFG_IDX_W    = 2;

    localparam logic CMD_TRANSLATE = 1'b0;
    localparam logic CMD_LOAD      = 1'b1;

    localparam logic [CFG_IDX_W-1:0] CFG_HEADER_SIZE       = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_SECTION_ALIGNMENT = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_FILE_ALIGNMENT    = 2'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_SECTION_COUNT     = 2'd3;

    localparam logic [ADDR_W-1:0] RESET_HEADER_SIZE       = 32'd0;
    localparam logic [ADDR_W-1:0] RESET_SECTION_ALIGNMENT = 32'd4096;
    localparam logic [ADDR_W-1:0] RESET_FILE_ALIGNMENT    = 32'd512;
    localparam logic [COUNT_W-1:0] RESET_SECTION_COUNT    = 5'd0;

    typedef struct packed {
        logic              cmd;
        logic [ADDR_W-1:0] rva;
        logic [SLOT_W-1:0] slot;
        logic [ADDR_W-1:0] start;
        logic [ADDR_W-1:0] length;
        logic [ADDR_W-1:0] raw;
        logic              found;
        logic [ADDR_W-1:0] result;
    } word_t;

endpackage

[design/srfo_cell.sv]
module srfo_cell (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic [srfo_pkg::IDX_W-1:0]     cell_idx,
    input  logic [srfo_pkg::COUNT_W-1:0]   section_count,
    input  logic                           in_valid,
    input  srfo_pkg::word_t                in_word,
    output logic                           out_valid,
    output srfo_pkg::word_t                out_word
);

    logic [srfo_pkg::ADDR_W-1:0] start_reg;
    logic [srfo_pkg::ADDR_W-1:0] length_reg;
    logic [srfo_pkg::ADDR_W-1:0] raw_reg;

    logic                        valid_reg;
    srfo_pkg::word_t             word_reg;
    srfo_pkg::word_t             word_next;

    logic                        slot_hit;
    logic                        active;
    logic [srfo_pkg::ADDR_W-1:0] end_addr;
    logic                        in_range;

    assign slot_hit = (srfo_pkg::CMP_W'(in_word.slot) == srfo_pkg::CMP_W'(cell_idx));
    assign active   = (srfo_pkg::CMP_W'(cell_idx) < srfo_pkg::CMP_W'(section_count));
    assign end_addr = start_reg + length_reg;
    assign in_range = (in_word.rva >= start_reg) && (in_word.rva < end_addr);

    always_comb
    begin
        word_next = in_word;
        if (in_word.cmd == srfo_pkg::CMD_TRANSLATE && !in_word.found && active && in_range)
        begin
            word_next.found  = 1'b1;
            word_next.result = raw_reg + in_word.rva - start_reg;
        end
    end

    // hold the table entry; write it when a load for this slot passes
    always_ff @(posedge clk)
    begin
        if (in_valid && in_word.cmd == srfo_pkg::CMD_LOAD && slot_hit)
        begin
            start_reg  <= in_word.start;
            length_reg <= in_word.length;
            raw_reg    <= in_word.raw;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        word_reg <= word_next;
    end

    assign out_valid = valid_reg;
    assign out_word  = word_reg;

endmodule

[design/section_rva_to_file_offset_unit.sv]
// The result strobe leaves the last cell; a word passes the entry register, then the 16 cells.
// Throughput: one word per cycle, loads and translates alike; busy stays low.
// Each cell holds one table entry; a word visits the cells in slot order.
// Reset clears the pipeline valid bits and loads the register reset values;
// table entries are undefined until loaded. The receiver cannot stall.
module section_rva_to_file_offset_unit (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             start,
    output logic                             busy,
    input  logic                             cmd,
    input  logic [31:0]                      virtual_offset,
    input  logic [3:0]                       entry_slot,
    input  logic [31:0]                      entry_start,
    input  logic [31:0]                      entry_length,
    input  logic [31:0]                      entry_raw_offset,
    output logic                             done,
    output logic [31:0]                      file_offset,
    output logic                             status,
    input  logic                             cfg_valid,
    output logic                             cfg_ready,
    input  logic [srfo_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  logic [31:0]                      cfg_data
);

    logic [srfo_pkg::ADDR_W-1:0]  header_size_reg;
    logic [srfo_pkg::ADDR_W-1:0]  section_alignment_reg;
    logic [srfo_pkg::ADDR_W-1:0]  file_alignment_reg;
    logic [srfo_pkg::COUNT_W-1:0] section_count_reg;

    logic                         head_valid_reg;
    srfo_pkg::word_t              head_word_reg;
    srfo_pkg::word_t              head_word_next;
    logic                         accept;
    logic                         pass_through;

    logic                         chain_valid [0:srfo_pkg::MAX_SECTIONS];
    srfo_pkg::word_t              chain_word  [0:srfo_pkg::MAX_SECTIONS];

    assign busy      = 1'b0;
    assign cfg_ready = 1'b1;
    assign accept    = start && !busy;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            header_size_reg       <= srfo_pkg::RESET_HEADER_SIZE;
            section_alignment_reg <= srfo_pkg::RESET_SECTION_ALIGNMENT;
            file_alignment_reg    <= srfo_pkg::RESET_FILE_ALIGNMENT;
            section_count_reg     <= srfo_pkg::RESET_SECTION_COUNT;
        end
        else if (cfg_valid && cfg_ready)
        begin
            case (cfg_index)
                srfo_pkg::CFG_HEADER_SIZE:       header_size_reg       <= cfg_data;
                srfo_pkg::CFG_SECTION_ALIGNMENT: section_alignment_reg <= cfg_data;
                srfo_pkg::CFG_FILE_ALIGNMENT:    file_alignment_reg    <= cfg_data;
                srfo_pkg::CFG_SECTION_COUNT:
                    section_count_reg <= cfg_data[srfo_pkg::COUNT_W-1:0];
                default: ;
            endcase
        end
    end

    assign pass_through = (virtual_offset < header_size_reg)
                       || (section_alignment_reg == file_alignment_reg);

    always_comb
    begin
        head_word_next.cmd    = cmd;
        head_word_next.rva    = virtual_offset;
        head_word_next.slot   = entry_slot;
        head_word_next.start  = entry_start;
        head_word_next.length = entry_length;
        head_word_next.raw    = entry_raw_offset;
        head_word_next.found  = pass_through;
        head_word_next.result = pass_through ? virtual_offset : '0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            head_valid_reg <= 1'b0;
        end
        else
        begin
            head_valid_reg <= accept;
        end
    end

    always_ff @(posedge clk)
    begin
        head_word_reg <= head_word_next;
    end

    assign chain_valid[0] = head_valid_reg;
    assign chain_word[0]  = head_word_reg;

    for (genvar k = 0; k < srfo_pkg::MAX_SECTIONS; k++)
    begin : g_cell
        srfo_cell u_cell (
            .clk           (clk),
            .rst_n         (rst_n),
            .cell_idx      (srfo_pkg::IDX_W'(k)),
            .section_count (section_count_reg),
            .in_valid      (chain_valid[k]),
            .in_word       (chain_word[k]),
            .out_valid     (chain_valid[k+1]),
            .out_word      (chain_word[k+1])
        );
    end

    assign done = chain_valid[srfo_pkg::MAX_SECTIONS]
               && (chain_word[srfo_pkg::MAX_SECTIONS].cmd == srfo_pkg::CMD_TRANSLATE);
    assign file_offset = chain_word[srfo_pkg::MAX_SECTIONS].result;
    assign status      = !chain_word[srfo_pkg::MAX_SECTIONS].found;

endmodule

[tb/testbench.sv]
`timescale 1ns / 1ps

module testbench;

    localparam int CYCLE_LIMIT   = 200000;
    localparam int DRAIN_CYCLES  = 24;
    localparam int RANDOM_PHASES = 12;
    localparam int PHASE_WORDS   = 34;
    localparam int REPORT_LIMIT  = 10;

    localparam logic ST_MAPPED = 1'b0;
    localparam logic ST_MISS   = 1'b1;

    typedef struct {
        logic        cmd;
        logic [31:0] rva;
        logic [3:0]  slot;
        logic [31:0] base;
        logic [31:0] size;
        logic [31:0] raw;
    } stim_t;

    typedef struct {
        logic [31:0] offset;
        logic        status;
    } lookup_t;

    logic                           clk = 1'b0;
    logic                           rst_n = 1'b0;
    logic                           start = 1'b0;
    logic                           busy;
    logic                           cmd = srfo_pkg::CMD_TRANSLATE;
    logic [31:0]                    virtual_offset = 32'd0;
    logic [3:0]                     entry_slot = 4'd0;
    logic [31:0]                    entry_start = 32'd0;
    logic [31:0]                    entry_length = 32'd0;
    logic [31:0]                    entry_raw_offset = 32'd0;
    logic                           done;
    logic [31:0]                    file_offset;
    logic                           status;
    logic                           cfg_valid = 1'b0;
    logic                           cfg_ready;
    logic [srfo_pkg::CFG_IDX_W-1:0] cfg_index = srfo_pkg::CFG_HEADER_SIZE;
    logic [31:0]                    cfg_data = 32'd0;

    section_rva_to_file_offset_unit u_dut (
        .clk              (clk),
        .rst_n            (rst_n),
        .start            (start),
        .busy             (busy),
        .cmd              (cmd),
        .virtual_offset   (virtual_offset),
        .entry_slot       (entry_slot),
        .entry_start      (entry_start),
        .entry_length     (entry_length),
        .entry_raw_offset (entry_raw_offset),
        .done             (done),
        .file_offset      (file_offset),
        .status           (status),
        .cfg_valid        (cfg_valid),
        .cfg_ready        (cfg_ready),
        .cfg_index        (cfg_index),
        .cfg_data         (cfg_data)
    );

    always
    begin
        #2 clk = 1'b1;
        #2 clk = 1'b0;
    end

    logic [31:0] hdr_size   = srfo_pkg::RESET_HEADER_SIZE;
    logic [31:0] sect_align = srfo_pkg::RESET_SECTION_ALIGNMENT;
    logic [31:0] file_align = srfo_pkg::RESET_FILE_ALIGNMENT;
    logic [4:0]  sect_count = srfo_pkg::RESET_SECTION_COUNT;
    logic [31:0] tbl_base [srfo_pkg::MAX_SECTIONS];
    logic [31:0] tbl_size [srfo_pkg::MAX_SECTIONS];
    logic [31:0] tbl_raw  [srfo_pkg::MAX_SECTIONS];
    logic [31:0] plan_base [srfo_pkg::MAX_SECTIONS];
    logic [31:0] plan_size [srfo_pkg::MAX_SECTIONS];

    stim_t   word_queue [$];
    lookup_t offset_queue [$];
    stim_t   cur_word;

    int gap_left = 0;
    int burst_left = 0;
    int cycle_count = 0;
    int error_count = 0;
    int lookup_count = 0;
    int miss_count = 0;
    int load_count = 0;
    int cfg_write_count = 0;

    function automatic lookup_t translate_rva(input logic [31:0] rva);
        lookup_t     r;
        int          n;
        logic [31:0] lim;
        r.offset = 32'd0;
        r.status = ST_MISS;
        if (rva < hdr_size || sect_align == file_align)
        begin
            r.offset = rva;
            r.status = ST_MAPPED;
            return r;
        end
        n = (sect_count > srfo_pkg::MAX_SECTIONS) ? srfo_pkg::MAX_SECTIONS : sect_count;
        for (int i = 0; i < n; i++)
        begin
            lim = tbl_base[i] + tbl_size[i];
            if (rva >= tbl_base[i] && rva < lim)
            begin
                r.offset = tbl_raw[i] + rva - tbl_base[i];
                r.status = ST_MAPPED;
                return r;
            end
        end
        return r;
    endfunction

    function automatic void apply_word(input stim_t w);
        lookup_t predicted;
        if (w.cmd == srfo_pkg::CMD_LOAD)
        begin
            tbl_base[w.slot] = w.base;
            tbl_size[w.slot] = w.size;
            tbl_raw[w.slot]  = w.raw;
            load_count++;
        end
        else
        begin
            predicted = translate_rva(w.rva);
            offset_queue.push_back(predicted);
            lookup_count++;
            if (predicted.status == ST_MISS)
                miss_count++;
        end
    endfunction

    function automatic void push_load(input logic [3:0] slot, input logic [31:0] base,
                                      input logic [31:0] size, input logic [31:0] raw);
        stim_t w;
        w.cmd  = srfo_pkg::CMD_LOAD;
        w.rva  = $urandom;
        w.slot = slot;
        w.base = base;
        w.size = size;
        w.raw  = raw;
        word_queue.push_back(w);
        plan_base[slot] = base;
        plan_size[slot] = size;
    endfunction

    function automatic void push_translate(input logic [31:0] rva);
        stim_t w;
        w.cmd  = srfo_pkg::CMD_TRANSLATE;
        w.rva  = rva;
        w.slot = 4'($urandom);
        w.base = $urandom;
        w.size = $urandom;
        w.raw  = $urandom;
        word_queue.push_back(w);
    endfunction

    function automatic logic [31:0] target_rva();
        int          k;
        logic [31:0] b;
        logic [31:0] s;
        k = $urandom_range(0, srfo_pkg::MAX_SECTIONS - 1);
        b = plan_base[k];
        s = plan_size[k];
        case ($urandom_range(0, 7))
            0: return b - 32'd1;
            1: return b;
            2: return b + s - 32'd1;
            3: return b + s;
            4: return (s == 32'd0) ? b : b + ($urandom % s);
            5: return hdr_size - $urandom_range(0, 1);
            6: return $urandom;
            default: return $urandom_range(0, 1) ? 32'hFFFF_FFFF : 32'h0;
        endcase
    endfunction

    function automatic logic [31:0] random_reg_value();
        case ($urandom_range(0, 4))
            0: return 32'h0;
            1: return 32'hFFFF_FFFF;
            2: return 32'd1 << $urandom_range(0, 16);
            3: return $urandom_range(0, 32'h4000);
            default: return $urandom;
        endcase
    endfunction

    task automatic write_reg(input logic [srfo_pkg::CFG_IDX_W-1:0] idx,
                             input logic [31:0] value);
        @(posedge clk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value;
        do
            @(posedge clk);
        while (!cfg_ready);
        cfg_valid <= 1'b0;
        cfg_write_count++;
        case (idx)
            srfo_pkg::CFG_HEADER_SIZE:       hdr_size   = value;
            srfo_pkg::CFG_SECTION_ALIGNMENT: sect_align = value;
            srfo_pkg::CFG_FILE_ALIGNMENT:    file_align = value;
            srfo_pkg::CFG_SECTION_COUNT:     sect_count = value[4:0];
            default: ;
        endcase
    endtask

    task automatic drain();
        do
            @(negedge clk);
        while (word_queue.size() != 0 || start || offset_queue.size() != 0);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    // feed one word per start, idle a drawn number of cycles before the next
    always @(posedge clk)
    begin
        if (!rst_n)
        begin
            start <= 1'b0;
        end
        else if (!start || !busy)
        begin
            if (start)
                apply_word(cur_word);
            if (gap_left != 0)
            begin
                gap_left--;
                start <= 1'b0;
            end
            else if (word_queue.size() != 0)
            begin
                cur_word = word_queue.pop_front();
                cmd              <= cur_word.cmd;
                virtual_offset   <= cur_word.rva;
                entry_slot       <= cur_word.slot;
                entry_start      <= cur_word.base;
                entry_length     <= cur_word.size;
                entry_raw_offset <= cur_word.raw;
                start            <= 1'b1;
                if (burst_left != 0)
                begin
                    burst_left--;
                    gap_left = 0;
                end
                else if ($urandom_range(0, 15) == 0)
                begin
                    burst_left = $urandom_range(8, 40);
                    gap_left = 0;
                end
                else
                begin
                    gap_left = $urandom_range(0, 19);
                end
            end
            else
            begin
                start <= 1'b0;
            end
        end
    end

    always @(posedge clk)
    begin
        lookup_t want;
        if (rst_n && done)
        begin
            if (offset_queue.size() == 0)
            begin
                error_count++;
                if (error_count <= REPORT_LIMIT)
                    $display("unexpected result: offset=%h status=%b", file_offset, status);
            end
            else
            begin
                want = offset_queue.pop_front();
                if (file_offset !== want.offset || status !== want.status)
                begin
                    error_count++;
                    if (error_count <= REPORT_LIMIT)
                        $display("mismatch: offset exp=%h got=%h, status exp=%b got=%b",
                                 want.offset, file_offset, want.status, status);
                end
            end
        end
    end

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("timeout after %0d cycles", cycle_count);
            $display("*** FAILED ***");
            $finish;
        end
    end

    initial
    begin
        logic [31:0] base;
        logic [31:0] size;
        logic [31:0] raw;
        logic [31:0] sa;
        logic [31:0] cnt;
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;

        // empty table at reset values: everything misses
        push_translate(32'h0000_1000);
        push_translate(32'hFFFF_FFFF);
        for (int i = 0; i < srfo_pkg::MAX_SECTIONS; i++)
        begin
            base = 32'h1000 * (i + 1);
            size = 32'h800;
            raw  = 32'h400 + 32'h200 * i;
            if (i == 0)
                raw = 32'hFFFF_FF00;
            if (i == 3)
                size = 32'h0;
            if (i == 5)
                base = 32'h5400;
            if (i == 14)
            begin
                base = 32'hFFFF_E000;
                size = 32'h1000;
            end
            if (i == 15)
            begin
                base = 32'hFFFF_F000;
                size = 32'h2000;
            end
            push_load(4'(i), base, size, raw);
        end

        drain();
        write_reg(srfo_pkg::CFG_SECTION_COUNT, 32'd16);
        push_translate(32'h0000_1000);
        push_translate(32'h0000_17FF);
        push_translate(32'h0000_1800);
        push_translate(32'h0000_4000);
        push_translate(32'h0000_5400);
        push_translate(32'hFFFF_F800);
        push_translate(32'hFFFF_E000);

        drain();
        write_reg(srfo_pkg::CFG_HEADER_SIZE, 32'h1800);
        push_translate(32'h0000_17FF);
        push_translate(32'h0000_1800);

        drain();
        write_reg(srfo_pkg::CFG_FILE_ALIGNMENT, 32'h1000);
        push_translate(32'hDEAD_BEEF);

        drain();
        write_reg(srfo_pkg::CFG_SECTION_ALIGNMENT, 32'h0);
        write_reg(srfo_pkg::CFG_HEADER_SIZE, 32'hFFFF_FFFF);
        write_reg(srfo_pkg::CFG_SECTION_COUNT, 32'd31);
        push_translate(32'hFFFF_FFFE);
        push_translate(32'hFFFF_FFFF);

        drain();
        write_reg(srfo_pkg::CFG_HEADER_SIZE, 32'h0);
        push_translate(32'h0000_E123);

        for (int p = 0; p < RANDOM_PHASES; p++)
        begin
            drain();
            write_reg(srfo_pkg::CFG_HEADER_SIZE, random_reg_value());
            sa = random_reg_value();
            write_reg(srfo_pkg::CFG_SECTION_ALIGNMENT, sa);
            write_reg(srfo_pkg::CFG_FILE_ALIGNMENT,
                      ($urandom_range(0, 3) == 0) ? sa : random_reg_value());
            case ($urandom_range(0, 5))
                0: cnt = 32'd0;
                1: cnt = 32'd16;
                2: cnt = 32'd31;
                default: cnt = $urandom_range(0, 31);
            endcase
            write_reg(srfo_pkg::CFG_SECTION_COUNT, cnt);
            for (int k = 0; k < PHASE_WORDS; k++)
            begin
                case ($urandom_range(0, 9))
                    0, 1: push_load(4'($urandom_range(0, srfo_pkg::MAX_SECTIONS - 1)),
                                    $urandom_range(1, 64) << 12,
                                    $urandom_range(0, 32'h3000), $urandom);
                    2: push_load(4'($urandom), $urandom, $urandom, $urandom);
                    default: push_translate(target_rva());
                endcase
            end
        end

        drain();
        $display("Ran %0d lookups (%0d not found) and %0d table loads", lookup_count,
                 miss_count, load_count);
        $display("Register writes: %0d, errors: %0d", cfg_write_count, error_count);
        if (error_count == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end

endmodule
